@@ design/msd_pkg.sv @@
// Shared types, constants and table functions of the matrix rectifier sector duty unit.
// Used by every module of the block; depends on nothing.
package msd_pkg;

  localparam int PERIOD_W = 15;
  localparam int MIN_W    = 14;
  localparam int DT_W     = 12;
  localparam int VIN_W    = 16;
  localparam int PH_W     = 18;
  localparam int MAG_W    = 17;
  localparam int Q_W      = 16;
  localparam int DEN_SH_W = MAG_W + PERIOD_W;
  localparam int ACC_W    = DEN_SH_W + 1;
  localparam int ALU_W    = ACC_W + 1;
  localparam int CNT_W    = 4;
  localparam int CMP_W    = 16;
  localparam int SEC_W    = 3;
  localparam int FORCE_W  = 6;
  localparam int NUM_LEGS = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 15'd5000;
  localparam logic [MIN_W-1:0]    MIN_RST    = 14'd100;
  localparam logic [DT_W-1:0]     DT_RST     = 12'd60;

  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_PHASE, S_SEL, S_MUL, S_DIV, S_CLAMP, S_OUT
  } seq_state_t;

  typedef enum logic [1:0] {CMP_PARK, CMP_DUTY, CMP_DUTY_DT} cmp_sel_t;
  typedef enum logic [1:0] {PH_A, PH_B, PH_C} phase_sel_t;

  typedef struct packed {
    logic             in_ready;
    logic             ld_phase;
    logic             ld_sel;
    logic             mul_step;
    logic             div_step;
    logic             ld_clamp;
    logic             ld_out;
    logic [CNT_W-1:0] bit_idx;
  } ctl_t;

  typedef struct packed {
    logic sec_zero;
    logic q_zero;
    logic out_free;
  } stat_t;

  function automatic logic [SEC_W-1:0] sector_of_pattern(input logic [2:0] pat);
    logic [SEC_W-1:0] s;
    case (pat)
      3'b100:  s = 3'd1;
      3'b110:  s = 3'd2;
      3'b010:  s = 3'd3;
      3'b011:  s = 3'd4;
      3'b001:  s = 3'd5;
      3'b101:  s = 3'd6;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  function automatic phase_sel_t num_phase(input logic [SEC_W-1:0] sec);
    phase_sel_t p;
    case (sec)
      3'd1, 3'd2: p = PH_B;
      3'd3, 3'd4: p = PH_C;
      default:    p = PH_A;
    endcase
    return p;
  endfunction

  function automatic phase_sel_t den_phase(input logic [SEC_W-1:0] sec);
    phase_sel_t p;
    case (sec)
      3'd2, 3'd5: p = PH_C;
      3'd3, 3'd6: p = PH_B;
      default:    p = PH_A;
    endcase
    return p;
  endfunction

  // Leg order is a1, b1, a2, b2, a3, b3.
  function automatic cmp_sel_t cmp_sel(input logic [SEC_W-1:0] sec, input int leg);
    cmp_sel_t c;
    c = CMP_PARK;
    case (sec)
      3'd1: if (leg == 3) c = CMP_DUTY; else if (leg == 5) c = CMP_DUTY_DT;
      3'd2: if (leg == 2) c = CMP_DUTY; else if (leg == 0) c = CMP_DUTY_DT;
      3'd3: if (leg == 5) c = CMP_DUTY; else if (leg == 1) c = CMP_DUTY_DT;
      3'd4: if (leg == 4) c = CMP_DUTY; else if (leg == 2) c = CMP_DUTY_DT;
      3'd5: if (leg == 1) c = CMP_DUTY; else if (leg == 3) c = CMP_DUTY_DT;
      3'd6: if (leg == 0) c = CMP_DUTY; else if (leg == 4) c = CMP_DUTY_DT;
      default: c = CMP_PARK;
    endcase
    return c;
  endfunction

  function automatic logic [FORCE_W-1:0] force_of_sector(input logic [SEC_W-1:0] sec);
    logic [FORCE_W-1:0] f;
    case (sec)
      3'd1, 3'd6: f = 6'd9;
      3'd2, 3'd3: f = 6'd36;
      3'd4, 3'd5: f = 6'd18;
      default:    f = 6'd0;
    endcase
    return f;
  endfunction

endpackage

@@ design/msd_addsub.sv @@
// Shared adder and subtractor used for both the shift-add multiply and the restoring divide.
// Depends on msd_pkg for the operand width.
module msd_addsub
  import msd_pkg::*;
(
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  input  logic             sub,
  output logic [ALU_W-1:0] y
);

  assign y = sub ? (a - b) : (a + b);

endmodule

@@ design/msd_seq.sv @@
// Sequencer of the sector duty unit: steps one request through phase, select, multiply,
// divide, clamp and output. Depends on msd_pkg for the state, control and status types.
module msd_seq
  import msd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  stat_t stat,
  output ctl_t  ctl
);

  seq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ctl         = '0;
    ctl.bit_idx = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        ctl.in_ready = 1'b1;
        if (in_valid) state_nxt = S_PHASE;
      end
      S_PHASE: begin
        ctl.ld_phase = 1'b1;
        state_nxt    = S_SEL;
      end
      S_SEL: begin
        ctl.ld_sel = 1'b1;
        if (stat.sec_zero) begin
          state_nxt = S_OUT;
        end else if (stat.q_zero) begin
          state_nxt = S_CLAMP;
        end else begin
          state_nxt = S_MUL;
          cnt_nxt   = CNT_W'(PERIOD_W - 1);
        end
      end
      S_MUL: begin
        ctl.mul_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DIV;
          cnt_nxt   = CNT_W'(Q_W - 1);
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (cnt_r == '0) state_nxt = S_CLAMP;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_CLAMP: begin
        ctl.ld_clamp = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          ctl.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ design/msd_fmt.sv @@
// Result formatter: turns sector and duty into intervals, leg compares and force levels.
// Depends on msd_pkg for widths and the compare and force tables.
module msd_fmt
  import msd_pkg::*;
(
  input  logic [SEC_W-1:0]                sector,
  input  logic [PERIOD_W-1:0]             duty,
  input  logic [PERIOD_W-1:0]             period,
  input  logic [DT_W-1:0]                 dead_time,
  output logic [PERIOD_W-1:0]             second,
  output logic [NUM_LEGS-1:0][CMP_W-1:0]  cmp,
  output logic [FORCE_W-1:0]              force_bits
);

  logic [CMP_W-1:0] park;
  logic [CMP_W-1:0] duty_ext;
  logic [CMP_W-1:0] duty_dt;

  assign park     = {1'b0, period} + CMP_W'(1);
  assign duty_ext = {1'b0, duty};
  assign duty_dt  = duty_ext + CMP_W'(dead_time);
  assign second   = (duty > period) ? '0 : (period - duty);
  assign force_bits = force_of_sector(sector);

  always_comb begin
    for (int j = 0; j < NUM_LEGS; j++) begin
      case (cmp_sel(sector, j))
        CMP_DUTY:    cmp[j] = duty_ext;
        CMP_DUTY_DT: cmp[j] = duty_dt;
        default:     cmp[j] = park;
      endcase
    end
  end

endmodule

@@ design/matrix_rectifier_sector_duty_unit.sv @@
// Top level of the matrix rectifier sector duty unit: configuration registers and datapath.
// Depends on msd_pkg, msd_addsub, msd_seq and msd_fmt.
//
// Each input request carries the line voltages uab and uca of one PWM period. The unit
// finds the input voltage sector, computes the duty trunc(period * ratio) exactly, clamps
// it and returns one result request with the sector, both intervals, six leg compares and
// the force levels. Configuration writes on the cfg_ channel set the period, the shortest
// interval and the dead time; they are taken at any time and must only be issued while
// no request is in flight.
// For each request one shared adder runs 15 shift-add multiply steps and 16 restoring
// divide steps. A request whose quotient is known to be zero skips both, and one with no
// valid sector also skips the clamp step. The next request is accepted in the cycle after
// the result is loaded into the output register, even while that result still waits for
// out_ready; a stalled receiver holds the unit in its output step once a second result
// is ready.
// Synchronous reset restores the default configuration, clears the held duty and empties
// the output register.
module matrix_rectifier_sector_duty_unit
  import msd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VIN_W-1:0]      in_uab,
  input  logic [VIN_W-1:0]      in_uca,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SEC_W-1:0]      out_sector,
  output logic [PERIOD_W-1:0]   out_first_interval,
  output logic [PERIOD_W-1:0]   out_second_interval,
  output logic [CMP_W-1:0]      out_cmp_a1,
  output logic [CMP_W-1:0]      out_cmp_b1,
  output logic [CMP_W-1:0]      out_cmp_a2,
  output logic [CMP_W-1:0]      out_cmp_b2,
  output logic [CMP_W-1:0]      out_cmp_a3,
  output logic [CMP_W-1:0]      out_cmp_b3,
  output logic [FORCE_W-1:0]    out_force_bits,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_t  ctl;
  stat_t stat;

  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [MIN_W-1:0]    min_r, min_nxt;
  logic [DT_W-1:0]     dt_r, dt_nxt;

  logic signed [VIN_W-1:0] uab_r, uab_nxt, uca_r, uca_nxt;
  logic signed [PH_W-1:0]  ph_a_r, ph_a_nxt, ph_b_r, ph_b_nxt, ph_c_r, ph_c_nxt;
  logic signed [PH_W-1:0]  ph_a_c, ph_b_c, ph_c_c;
  logic [SEC_W-1:0]        sector_r, sector_nxt;
  logic [MAG_W-1:0]        num_r, num_nxt;
  logic [DEN_SH_W-1:0]     den_sh_r, den_sh_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [Q_W-1:0]          q_r, q_nxt;
  logic [PERIOD_W-1:0]     last_duty_r, last_duty_nxt;

  logic signed [PH_W-1:0]  ph_num, ph_den, num_s, den_a;
  logic [ALU_W-1:0]        alu_a, alu_b, alu_y;

  logic [PERIOD_W-1:0]     q_c, min15, hi, rem, duty_c;

  logic [PERIOD_W-1:0]                fmt_second;
  logic [NUM_LEGS-1:0][CMP_W-1:0]     fmt_cmp;
  logic [FORCE_W-1:0]                 fmt_force;

  logic                               out_valid_r, out_valid_nxt;
  logic [SEC_W-1:0]                   o_sector_r;
  logic [PERIOD_W-1:0]                o_first_r, o_second_r;
  logic [NUM_LEGS-1:0][CMP_W-1:0]     o_cmp_r;
  logic [FORCE_W-1:0]                 o_force_r;

  msd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctl      (ctl)
  );

  msd_addsub u_addsub (
    .a   (alu_a),
    .b   (alu_b),
    .sub (ctl.div_step),
    .y   (alu_y)
  );

  msd_fmt u_fmt (
    .sector     (sector_r),
    .duty       (last_duty_r),
    .period     (period_r),
    .dead_time  (dt_r),
    .second     (fmt_second),
    .cmp        (fmt_cmp),
    .force_bits (fmt_force)
  );

  assign in_ready  = ctl.in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    period_nxt = period_r;
    min_nxt    = min_r;
    dt_nxt     = dt_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_PWM_PERIOD:   period_nxt = cfg_data[PERIOD_W-1:0];
        REG_MIN_INTERVAL: min_nxt    = cfg_data[MIN_W-1:0];
        REG_DEAD_TIME:    dt_nxt     = cfg_data[DT_W-1:0];
        default: ;
      endcase
    end
  end

  assign ph_a_c = PH_W'(uab_r) - PH_W'(uca_r);
  assign ph_b_c = -((PH_W'(uab_r) <<< 1) + PH_W'(uca_r));
  assign ph_c_c = PH_W'(uab_r) + (PH_W'(uca_r) <<< 1);

  always_comb begin
    case (num_phase(sector_r))
      PH_B:    ph_num = ph_b_r;
      PH_C:    ph_num = ph_c_r;
      default: ph_num = ph_a_r;
    endcase
    case (den_phase(sector_r))
      PH_B:    ph_den = ph_b_r;
      PH_C:    ph_den = ph_c_r;
      default: ph_den = ph_a_r;
    endcase
  end

  assign num_s = ph_den[PH_W-1] ? ph_num : -ph_num;
  assign den_a = ph_den[PH_W-1] ? -ph_den : ph_den;

  assign stat.sec_zero = (sector_r == '0);
  assign stat.q_zero   = (den_a == '0) || num_s[PH_W-1] || (num_s == '0);
  assign stat.out_free = !out_valid_r || out_ready;

  assign alu_a = ctl.div_step ? {1'b0, acc_r} : {acc_r, 1'b0};
  assign alu_b = ctl.div_step ? {2'b00, den_sh_r}
               : (period_r[ctl.bit_idx] ? ALU_W'(num_r) : '0);

  assign q_c    = (q_r > {1'b0, period_r}) ? period_r : q_r[PERIOD_W-1:0];
  assign min15  = {1'b0, min_r};
  assign hi     = (period_r >= min15) ? (period_r - min15) : '0;
  assign rem    = period_r - q_c;
  assign duty_c = (q_c <= min15) ? min15 : ((rem <= min15) ? hi : q_c);

  always_comb begin
    uab_nxt       = uab_r;
    uca_nxt       = uca_r;
    ph_a_nxt      = ph_a_r;
    ph_b_nxt      = ph_b_r;
    ph_c_nxt      = ph_c_r;
    sector_nxt    = sector_r;
    num_nxt       = num_r;
    den_sh_nxt    = den_sh_r;
    acc_nxt       = acc_r;
    q_nxt         = q_r;
    last_duty_nxt = last_duty_r;
    if (ctl.in_ready && in_valid) begin
      uab_nxt = in_uab;
      uca_nxt = in_uca;
    end
    if (ctl.ld_phase) begin
      ph_a_nxt   = ph_a_c;
      ph_b_nxt   = ph_b_c;
      ph_c_nxt   = ph_c_c;
      sector_nxt = sector_of_pattern({!ph_a_c[PH_W-1], !ph_b_c[PH_W-1], !ph_c_c[PH_W-1]});
    end
    if (ctl.ld_sel) begin
      num_nxt    = num_s[MAG_W-1:0];
      den_sh_nxt = {den_a[MAG_W-1:0], {PERIOD_W{1'b0}}};
      acc_nxt    = '0;
      q_nxt      = '0;
    end
    if (ctl.mul_step) begin
      acc_nxt = alu_y[ACC_W-1:0];
    end
    if (ctl.div_step) begin
      if (!alu_y[ALU_W-1]) acc_nxt = alu_y[ACC_W-1:0];
      q_nxt      = {q_r[Q_W-2:0], !alu_y[ALU_W-1]};
      den_sh_nxt = den_sh_r >> 1;
    end
    if (ctl.ld_clamp) begin
      last_duty_nxt = duty_c;
    end
  end

  assign out_valid_nxt = ctl.ld_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RST;
      min_r       <= MIN_RST;
      dt_r        <= DT_RST;
      last_duty_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      period_r    <= period_nxt;
      min_r       <= min_nxt;
      dt_r        <= dt_nxt;
      last_duty_r <= last_duty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    uab_r    <= uab_nxt;
    uca_r    <= uca_nxt;
    ph_a_r   <= ph_a_nxt;
    ph_b_r   <= ph_b_nxt;
    ph_c_r   <= ph_c_nxt;
    sector_r <= sector_nxt;
    num_r    <= num_nxt;
    den_sh_r <= den_sh_nxt;
    acc_r    <= acc_nxt;
    q_r      <= q_nxt;
    if (ctl.ld_out) begin
      o_sector_r <= sector_r;
      o_first_r  <= last_duty_r;
      o_second_r <= fmt_second;
      o_cmp_r    <= fmt_cmp;
      o_force_r  <= fmt_force;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sector          = o_sector_r;
  assign out_first_interval  = o_first_r;
  assign out_second_interval = o_second_r;
  assign out_cmp_a1          = o_cmp_r[0];
  assign out_cmp_b1          = o_cmp_r[1];
  assign out_cmp_a2          = o_cmp_r[2];
  assign out_cmp_b2          = o_cmp_r[3];
  assign out_cmp_a3          = o_cmp_r[4];
  assign out_cmp_b3          = o_cmp_r[5];
  assign out_force_bits      = o_force_r;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while a request is in flight");

  a_clamp_after_divide: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ld_clamp |-> $past(ctl.div_step) || $past(ctl.ld_sel))
    else $error("clamp step without a finished divide");

  a_park_no_sector: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sector == '0 |-> out_force_bits == '0)
    else $error("force levels set without a valid sector");
`endif

endmodule
